// File: rtl/gcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared widths, constants and fixed-point helpers for the GRU cell step.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int MAX_UNITS    = 64;
  localparam int MAX_FEATURES = 64;
  localparam int VALUE_W      = 16;
  localparam int FRAC_BITS    = 11;
  localparam int COLS         = 3 * MAX_UNITS;
  localparam int ACC_W        = 40;
  localparam int WADDR_W      = $clog2(MAX_UNITS * COLS);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  localparam acc_t HALF_ACC = acc_t'(1) <<< (FRAC_BITS - 1);

  // Round half up to FRAC_BITS and saturate to a value
  function automatic value_t rnd_sat(input acc_t v);
    acc_t s;
    acc_t q;
    s = v + HALF_ACC;
    q = s >>> FRAC_BITS;
    if (q > acc_t'(32767)) return value_t'(32767);
    if (q < -acc_t'(32768)) return value_t'(-32768);
    return value_t'(q);
  endfunction

  // Piecewise-linear sigmoid, result in 0..ONE
  function automatic value_t sigm(input logic signed [17:0] x);
    logic [17:0] a;
    logic [12:0] y;
    value_t      yv;
    a = x[17] ? 18'(-x) : 18'(x);
    if (a >= 18'd10240) y = 13'd2048;
    else if (a >= 18'd4864) y = 13'(a >> 5) + 13'd1728;
    else if (a >= 18'd2048) y = 13'(a >> 3) + 13'd1280;
    else y = 13'(a >> 2) + 13'd1024;
    yv = value_t'({3'b000, y});
    return x[17] ? (value_t'(2048) - yv) : yv;
  endfunction

  function automatic value_t tanh_act(input value_t x);
    value_t s;
    s = sigm({x[15], x, 1'b0});
    return value_t'((s <<< 1) - value_t'(2048));
  endfunction

endpackage
`default_nettype wire

// File: rtl/gru_cell_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Load requests are taken one per cycle while the block is idle and produce no result.
// A compute request walks each of the 3U gate columns through one multiply-accumulate
// pipeline, with an r*h pass over the U units when the reset gate comes first, or T1, T2
// and T3 steps per candidate column when it comes after; then emits U results, holding each
// while the receiver stalls. Weight and vector memories are synchronous RAMs with registered reads.
// Synchronous active-low reset clears control and config; memories are not cleared.
// ----------------------------------------------------------------------------
// gru_cell_step
// One forward step of a GRU cell over memory-resident weights and vectors.
// ----------------------------------------------------------------------------
module gru_cell_step
  import gcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_func,
  input  wire logic [5:0]         in_row,
  input  wire logic [7:0]         in_column,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [5:0]              out_index,
  output logic signed [15:0]      out_hidden_value,
  output logic                    out_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [2:0] F_WIH = 3'd0, F_WHH = 3'd1, F_BIN = 3'd2, F_BREC = 3'd3,
                         F_X = 3'd4, F_H = 3'd5, F_COMP = 3'd6;
  localparam logic [1:0] R_UNITS = 2'd0, R_FEAT = 2'd1, R_BIAS = 2'd2, R_RAFTER = 2'd3;
  localparam logic [1:0] BM_SEP = 2'd0, BM_MERGED = 2'd1;

  localparam logic [3:0] S_IDLE = 4'd0, S_ISSUE = 4'd1, S_DRAIN = 4'd2, S_T1 = 4'd3,
                         S_T2 = 4'd4, S_T3 = 4'd5, S_FIN1 = 4'd6, S_FIN2 = 4'd7,
                         S_RH = 4'd8, S_RHDR = 4'd9, S_ORD = 4'd10, S_OMUL = 4'd11,
                         S_OSUM = 4'd12;
  localparam logic PH_ZR = 1'b0, PH_G = 1'b1;
  localparam logic [1:0] TAG_X = 2'd0, TAG_H = 2'd1, TAG_T = 2'd2, TAG_RH = 2'd3;

  // configuration
  logic [6:0] units_r, feat_r;
  logic [1:0] bias_mode_r;
  logic       reset_after_r;
  logic       cfg_wr;
  logic [6:0] cfg_clamped;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    cfg_clamped = pwdata[6:0];
    if (cfg_clamped == 7'd0) cfg_clamped = 7'd1;
    else if (cfg_clamped > 7'd64) cfg_clamped = 7'd64;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r       <= 7'd64;
      feat_r        <= 7'd64;
      bias_mode_r   <= BM_SEP;
      reset_after_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        R_UNITS:  units_r       <= cfg_clamped;
        R_FEAT:   feat_r        <= cfg_clamped;
        R_BIAS:   bias_mode_r   <= pwdata[1:0];
        R_RAFTER: reset_after_r <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      R_UNITS:  prdata = {25'd0, units_r};
      R_FEAT:   prdata = {25'd0, feat_r};
      R_BIAS:   prdata = {30'd0, bias_mode_r};
      R_RAFTER: prdata = {31'd0, reset_after_r};
      default:  prdata = 32'd0;
    endcase
  end

  // control
  logic [3:0] state_r;
  logic       phase_r;
  logic [5:0] idx_r;
  logic       seg_r;
  logic [7:0] wcol_r;
  logic       sep, merged;
  logic [7:0] u8, two_u, three_u;
  logic       in_acc;

  assign sep     = (bias_mode_r == BM_SEP);
  assign merged  = (bias_mode_r == BM_MERGED);
  assign u8      = {1'b0, units_r};
  assign two_u   = u8 << 1;
  assign three_u = two_u + u8;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;

  // memory addressing
  logic [WADDR_W-1:0] rd_waddr, ld_waddr;
  logic [5:0]         r_addr;

  assign rd_waddr = WADDR_W'({idx_r, 7'd0}) + WADDR_W'({idx_r, 6'd0}) + WADDR_W'(wcol_r);
  assign ld_waddr = WADDR_W'({in_row, 7'd0}) + WADDR_W'({in_row, 6'd0})
                  + WADDR_W'(in_column);
  assign r_addr   = (phase_r == PH_G) ? 6'(wcol_r - two_u) : idx_r;

  value_t wih_mem [MAX_FEATURES*COLS];
  value_t whh_mem [MAX_UNITS*COLS];
  value_t bin_mem [COLS];
  value_t brec_mem [COLS];
  value_t x_mem [MAX_FEATURES];
  value_t h_mem [MAX_UNITS];
  value_t rh_mem [MAX_UNITS];
  value_t z_mem [MAX_UNITS];
  value_t r_mem [MAX_UNITS];
  value_t g_mem [MAX_UNITS];

  value_t wih_q, whh_q, bin_q, brec_q, x_q, h_q, rh_q, z_q, r_q, g_q;

  logic ld_wih, ld_whh, ld_bin, ld_brec, ld_x, ld_h, col_ok;
  assign col_ok  = (in_column < 8'(COLS));
  assign ld_wih  = in_acc && in_func == F_WIH && col_ok;
  assign ld_whh  = in_acc && in_func == F_WHH && col_ok;
  assign ld_bin  = in_acc && in_func == F_BIN && col_ok;
  assign ld_brec = in_acc && in_func == F_BREC && col_ok;
  assign ld_x    = in_acc && in_func == F_X;
  assign ld_h    = in_acc && in_func == F_H;

  always_ff @(posedge clk) begin
    if (ld_wih) wih_mem[ld_waddr] <= in_value;
    wih_q <= wih_mem[rd_waddr];
  end

  always_ff @(posedge clk) begin
    if (ld_whh) whh_mem[ld_waddr] <= in_value;
    whh_q <= whh_mem[rd_waddr];
  end

  always_ff @(posedge clk) begin
    if (ld_bin) bin_mem[in_column] <= in_value;
    bin_q <= bin_mem[wcol_r];
  end

  always_ff @(posedge clk) begin
    if (ld_brec) brec_mem[in_column] <= in_value;
    brec_q <= brec_mem[wcol_r];
  end

  always_ff @(posedge clk) begin
    if (ld_x) x_mem[in_row] <= in_value;
    x_q <= x_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (ld_h) h_mem[in_row] <= in_value;
    h_q <= h_mem[idx_r];
  end

  // pipeline: read -> multiply -> accumulate
  logic       s1_v_r, s2_v_r;
  logic [1:0] s1_tag_r, s2_tag_r;
  logic [5:0] s1_idx_r, s2_idx_r;
  logic signed [31:0] prod_r;
  acc_t       acc_r, tacc_r;
  value_t     pre_r, tpre_r, act;
  logic signed [31:0] tprod_r;
  logic       issue, rh_issue, pipe_busy;
  logic [1:0] issue_tag;
  logic       rh_wr, gate_wr;
  acc_t       bias_term;

  assign issue     = (state_r == S_ISSUE);
  assign rh_issue  = (state_r == S_RH);
  assign pipe_busy = s1_v_r | s2_v_r;
  assign issue_tag = rh_issue ? TAG_RH :
                     !seg_r ? TAG_X :
                     (phase_r == PH_G && reset_after_r) ? TAG_T : TAG_H;
  assign rh_wr     = s2_v_r && s2_tag_r == TAG_RH;
  assign gate_wr   = (state_r == S_FIN2);

  always_ff @(posedge clk) begin
    if (rh_wr) rh_mem[s2_idx_r] <= rnd_sat(acc_t'(prod_r));
    rh_q <= rh_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (gate_wr && phase_r == PH_ZR && wcol_r < u8) z_mem[wcol_r[5:0]] <= act;
    z_q <= z_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (gate_wr && phase_r == PH_ZR && wcol_r >= u8) r_mem[6'(wcol_r - u8)] <= act;
    r_q <= r_mem[r_addr];
  end

  always_ff @(posedge clk) begin
    if (gate_wr && phase_r == PH_G) g_mem[6'(wcol_r - two_u)] <= act;
    g_q <= g_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue | rh_issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= issue_tag;
    s1_idx_r <= idx_r;
    s2_tag_r <= s1_tag_r;
    s2_idx_r <= s1_idx_r;
    case (s1_tag_r)
      TAG_X:   prod_r <= x_q * wih_q;
      TAG_RH:  prod_r <= r_q * h_q;
      default: prod_r <= ((phase_r == PH_G && !reset_after_r) ? rh_q : h_q) * whh_q;
    endcase
  end

  always_comb begin
    if (phase_r == PH_G && reset_after_r)
      bias_term = (sep || merged) ? (acc_t'(bin_q) <<< FRAC_BITS) : '0;
    else if (sep)
      bias_term = (acc_t'(bin_q) + acc_t'(brec_q)) <<< FRAC_BITS;
    else if (merged)
      bias_term = acc_t'(bin_q) <<< FRAC_BITS;
    else
      bias_term = '0;
  end

  assign act = (phase_r == PH_G) ? tanh_act(pre_r) : sigm({{2{pre_r[15]}}, pre_r});

  // output products
  logic signed [31:0] p1_r, p2_r;
  logic out_valid_r, out_last_r;
  logic [5:0] out_index_r;
  value_t out_hidden_r;
  logic out_load;

  assign out_load = (state_r == S_OSUM) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (state_r == S_OMUL) begin
      p1_r <= z_q * h_q;
      p2_r <= (value_t'(2048) - z_q) * g_q;
    end
    if (out_load) begin
      out_hidden_r <= rnd_sat(acc_t'(p1_r) + acc_t'(p2_r));
      out_index_r  <= idx_r;
      out_last_r   <= ({1'b0, idx_r} == units_r - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid        = out_valid_r;
  assign out_index        = out_index_r;
  assign out_hidden_value = out_hidden_r;
  assign out_last         = out_last_r;

  // accumulators
  always_ff @(posedge clk) begin
    if ((in_acc && in_func == F_COMP) || state_r == S_FIN2) begin
      acc_r  <= '0;
      tacc_r <= '0;
    end else if (s2_v_r && s2_tag_r != TAG_RH) begin
      if (s2_tag_r == TAG_T) tacc_r <= tacc_r + acc_t'(prod_r);
      else acc_r <= acc_r + acc_t'(prod_r);
    end else if (state_r == S_T3) begin
      acc_r <= acc_r + acc_t'(tprod_r);
    end
    if (state_r == S_T1)
      tpre_r <= rnd_sat(tacc_r + (sep ? (acc_t'(brec_q) <<< FRAC_BITS) : '0));
    if (state_r == S_T2) tprod_r <= r_q * tpre_r;
    if (state_r == S_FIN1) pre_r <= rnd_sat(acc_r + bias_term);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_ZR;
      idx_r   <= '0;
      seg_r   <= 1'b0;
      wcol_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_func == F_COMP) begin
            state_r <= S_ISSUE;
            phase_r <= PH_ZR;
            idx_r   <= '0;
            seg_r   <= 1'b0;
            wcol_r  <= '0;
          end
        end
        S_ISSUE: begin
          if (!seg_r) begin
            if ({1'b0, idx_r} == feat_r - 7'd1) begin
              seg_r <= 1'b1;
              idx_r <= '0;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end else if ({1'b0, idx_r} == units_r - 7'd1) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 6'd1;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy)
            state_r <= (phase_r == PH_G && reset_after_r) ? S_T1 : S_FIN1;
        end
        S_T1: state_r <= S_T2;
        S_T2: state_r <= S_T3;
        S_T3: state_r <= S_FIN1;
        S_FIN1: state_r <= S_FIN2;
        S_FIN2: begin
          idx_r <= '0;
          seg_r <= 1'b0;
          if (phase_r == PH_ZR) begin
            if (wcol_r == two_u - 8'd1) begin
              if (reset_after_r) begin
                phase_r <= PH_G;
                wcol_r  <= two_u;
                state_r <= S_ISSUE;
              end else begin
                state_r <= S_RH;
              end
            end else begin
              wcol_r  <= wcol_r + 8'd1;
              state_r <= S_ISSUE;
            end
          end else if (wcol_r == three_u - 8'd1) begin
            state_r <= S_ORD;
          end else begin
            wcol_r  <= wcol_r + 8'd1;
            state_r <= S_ISSUE;
          end
        end
        S_RH: begin
          if ({1'b0, idx_r} == units_r - 7'd1) state_r <= S_RHDR;
          else idx_r <= idx_r + 6'd1;
        end
        S_RHDR: begin
          if (!pipe_busy) begin
            phase_r <= PH_G;
            wcol_r  <= two_u;
            idx_r   <= '0;
            seg_r   <= 1'b0;
            state_r <= S_ISSUE;
          end
        end
        S_ORD: state_r <= S_OMUL;
        S_OMUL: state_r <= S_OSUM;
        S_OSUM: begin
          if (out_load) begin
            if ({1'b0, idx_r} == units_r - 7'd1) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 6'd1;
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_gru_cell_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gru_cell_step
// Drives load and compute requests into the GRU cell step and predicts each
// new hidden value from its own copy of the weights, vectors and settings.
// Results are compared field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_gru_cell_step;
  import gcs_pkg::*;

  localparam logic [2:0] F_LD_WIH = 3'd0;
  localparam logic [2:0] F_LD_WHH = 3'd1;
  localparam logic [2:0] F_LD_BIN = 3'd2;
  localparam logic [2:0] F_LD_BREC = 3'd3;
  localparam logic [2:0] F_LD_X = 3'd4;
  localparam logic [2:0] F_LD_H = 3'd5;
  localparam logic [2:0] F_COMPUTE = 3'd6;
  localparam logic [2:0] F_UNUSED = 3'd7;

  localparam logic [3:0] REG_UNITS = 4'd0;
  localparam logic [3:0] REG_FEATURES = 4'd4;
  localparam logic [3:0] REG_BIAS_MODE = 4'd8;
  localparam logic [3:0] REG_RESET_AFTER = 4'd12;

  localparam int BM_SEPARATE = 0;
  localparam int BM_MERGED = 1;
  localparam longint ONE_Q = 2048;

  typedef struct {
    logic [5:0]  index;
    logic [15:0] hval;
    logic        last;
  } hidden_res_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [2:0] in_func;
  logic [5:0] in_row;
  logic [7:0] in_column;
  logic signed [15:0] in_value;
  logic out_valid, out_ready;
  logic [5:0] out_index;
  logic signed [15:0] out_hidden_value;
  logic out_last;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  gru_cell_step u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_row(in_row),
    .in_column(in_column), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .out_hidden_value(out_hidden_value), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow state of the cell
  longint w_in [MAX_FEATURES*COLS];
  longint w_rec [MAX_UNITS*COLS];
  longint b_in [COLS];
  longint b_rec [COLS];
  longint x_vec [MAX_FEATURES];
  longint h_prev [MAX_UNITS];
  longint gates [COLS];
  bit w_in_ok [MAX_FEATURES*COLS];
  bit w_rec_ok [MAX_UNITS*COLS];
  bit b_in_ok [COLS];
  bit b_rec_ok [COLS];
  bit x_ok [MAX_FEATURES];
  bit h_ok [MAX_UNITS];
  int units_q, feats_q, bias_q, after_q;

  hidden_res_t hidden_q[$];
  int errors, n_reqs, n_computes, n_results;
  bit quiet;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint rnd_q(longint v);
    longint q;
    q = (v + 1024) >>> 11;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic longint sigmoid_q(longint v);
    longint a, y;
    a = v < 0 ? -v : v;
    if (a >= 10240) y = ONE_Q;
    else if (a >= 4864) y = (a >> 5) + 1728;
    else if (a >= 2048) y = (a >> 3) + 1280;
    else y = (a >> 2) + 1024;
    return v < 0 ? ONE_Q - y : y;
  endfunction

  function automatic int clamp_cfg(int v);
    v = v & 'h7F;
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // one GRU step over the shadow state; queue one result per unit
  function automatic void predict_hidden();
    longint acc, t, z, hn;
    longint rh [MAX_UNITS];
    int c;
    bit sep, mrg;
    hidden_res_t r;
    sep = bias_q == BM_SEPARATE;
    mrg = bias_q == BM_MERGED;
    for (int j = 0; j < 2 * units_q; j++) begin
      acc = 0;
      for (int i = 0; i < feats_q; i++) acc += x_vec[i] * w_in[i*COLS+j];
      for (int i = 0; i < units_q; i++) acc += h_prev[i] * w_rec[i*COLS+j];
      if (sep) acc += (b_in[j] + b_rec[j]) * ONE_Q;
      else if (mrg) acc += b_in[j] * ONE_Q;
      gates[j] = sigmoid_q(rnd_q(acc));
    end
    if (!after_q)
      for (int i = 0; i < units_q; i++) rh[i] = rnd_q(gates[units_q+i] * h_prev[i]);
    for (int j = 0; j < units_q; j++) begin
      c = 2 * units_q + j;
      acc = 0;
      for (int i = 0; i < feats_q; i++) acc += x_vec[i] * w_in[i*COLS+c];
      if (after_q) begin
        t = 0;
        for (int i = 0; i < units_q; i++) t += h_prev[i] * w_rec[i*COLS+c];
        if (sep) t += b_rec[c] * ONE_Q;
        acc += gates[units_q+j] * rnd_q(t);
      end else begin
        for (int i = 0; i < units_q; i++) acc += rh[i] * w_rec[i*COLS+c];
        if (sep) acc += b_rec[c] * ONE_Q;
      end
      if (sep || mrg) acc += b_in[c] * ONE_Q;
      gates[c] = 2 * sigmoid_q(2 * rnd_q(acc)) - ONE_Q;
    end
    for (int j = 0; j < units_q; j++) begin
      z = gates[j];
      hn = rnd_q(z * h_prev[j] + (ONE_Q - z) * gates[2*units_q+j]);
      r.index = 6'(j);
      r.hval = 16'(hn);
      r.last = (j + 1 == units_q);
      hidden_q.push_back(r);
    end
  endfunction

  function automatic void apply_request(logic [2:0] f, int row, int col, longint v);
    case (f)
      F_LD_WIH: if (col < COLS) begin
        w_in[row*COLS+col] = v;
        w_in_ok[row*COLS+col] = 1;
      end
      F_LD_WHH: if (col < COLS) begin
        w_rec[row*COLS+col] = v;
        w_rec_ok[row*COLS+col] = 1;
      end
      F_LD_BIN: if (col < COLS) begin
        b_in[col] = v;
        b_in_ok[col] = 1;
      end
      F_LD_BREC: if (col < COLS) begin
        b_rec[col] = v;
        b_rec_ok[col] = 1;
      end
      F_LD_X: begin
        x_vec[row] = v;
        x_ok[row] = 1;
      end
      F_LD_H: begin
        h_prev[row] = v;
        h_ok[row] = 1;
      end
      F_COMPUTE: begin
        predict_hidden();
        n_computes++;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(1200)) - 16'd600;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_req(logic [2:0] f, logic [5:0] row, logic [7:0] col,
                          logic [15:0] v);
    in_valid <= 1'b1;
    in_func <= f;
    in_row <= row;
    in_column <= col;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    apply_request(f, row, col, longint'($signed(v)));
    n_reqs++;
    @(negedge clk);
    if (!quiet && $urandom_range(7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (hidden_q.size() != 0) @(negedge clk);
    // loads leave nothing to wait for; allow the pipeline to settle
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, int v);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      REG_UNITS: units_q = clamp_cfg(v);
      REG_FEATURES: feats_q = clamp_cfg(v);
      REG_BIAS_MODE: bias_q = v & 3;
      REG_RESET_AFTER: after_q = v & 1;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // load every entry the next compute reads that was never written
  task automatic fill_missing();
    for (int i = 0; i < feats_q; i++)
      for (int c = 0; c < 3 * units_q; c++)
        if (!w_in_ok[i*COLS+c]) send_req(F_LD_WIH, 6'(i), 8'(c), rand_value());
    for (int i = 0; i < units_q; i++)
      for (int c = 0; c < 3 * units_q; c++)
        if (!w_rec_ok[i*COLS+c]) send_req(F_LD_WHH, 6'(i), 8'(c), rand_value());
    for (int c = 0; c < 3 * units_q; c++) begin
      if (!b_in_ok[c]) send_req(F_LD_BIN, 6'($urandom), 8'(c), rand_value());
      if (!b_rec_ok[c]) send_req(F_LD_BREC, 6'($urandom), 8'(c), rand_value());
    end
    for (int i = 0; i < feats_q; i++)
      if (!x_ok[i]) send_req(F_LD_X, 6'(i), 8'($urandom), rand_value());
    for (int i = 0; i < units_q; i++)
      if (!h_ok[i]) send_req(F_LD_H, 6'(i), 8'($urandom), rand_value());
  endtask

  task automatic random_load();
    logic [2:0] f;
    f = 3'($urandom_range(5));
    send_req(f, 6'($urandom_range(feats_q < units_q ? units_q - 1 : feats_q - 1)),
             8'($urandom_range(3 * units_q - 1)), rand_value());
  endtask

  task automatic test_directed();
    write_reg(REG_UNITS, 0);
    write_reg(REG_FEATURES, 0);
    // extremes of the stored values on the smallest cell
    send_req(F_LD_WIH, 6'd0, 8'd0, 16'h7FFF);
    send_req(F_LD_WIH, 6'd0, 8'd1, 16'h8000);
    send_req(F_LD_WIH, 6'd0, 8'd2, 16'h0000);
    send_req(F_LD_X, 6'd0, 8'hFF, 16'h0800);
    send_req(F_LD_H, 6'd0, 8'd0, 16'h8000);
    fill_missing();
    send_req(F_COMPUTE, 6'd0, 8'd0, 16'd0);
    // ignored requests (column past the gate blocks, unused selector), then last-column loads
    send_req(F_LD_WIH, 6'd63, 8'd192, 16'h1234);
    send_req(F_LD_WHH, 6'd63, 8'd255, 16'h4321);
    send_req(F_LD_BIN, 6'd0, 8'd200, 16'h7FFF);
    send_req(F_UNUSED, 6'd63, 8'd255, 16'hFFFF);
    send_req(F_LD_WIH, 6'd63, 8'd191, 16'h0100);
    send_req(F_LD_BREC, 6'd63, 8'd191, 16'hFF00);
    send_req(F_COMPUTE, 6'd63, 8'd255, 16'hFFFF);
    write_reg(REG_UNITS, 3);
    write_reg(REG_FEATURES, 2);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_BIAS_MODE, m);
      for (int a = 0; a < 2; a++) begin
        write_reg(REG_RESET_AFTER, a);
        fill_missing();
        send_req(F_COMPUTE, 6'd0, 8'd0, 16'd0);
      end
    end
  endtask

  // sizes written above the limit and above seven bits
  task automatic test_wide_config();
    write_reg(REG_UNITS, 100);
    write_reg(REG_FEATURES, 127);
    write_reg(REG_UNITS, 130);
    write_reg(REG_FEATURES, 129);
    write_reg(REG_BIAS_MODE, BM_SEPARATE);
    write_reg(REG_RESET_AFTER, 1);
    fill_missing();
    send_req(F_COMPUTE, 6'd0, 8'd0, 16'd0);
    write_reg(REG_RESET_AFTER, 0);
    write_reg(REG_BIAS_MODE, BM_MERGED);
    send_req(F_COMPUTE, 6'd0, 8'd0, 16'd0);
  endtask

  task automatic test_random();
    int loads;
    while (n_reqs < 270) begin
      if ($urandom_range(3) == 0) begin
        write_reg(REG_UNITS, $urandom_range(4, 1));
        write_reg(REG_FEATURES, $urandom_range(4, 1));
        write_reg(REG_BIAS_MODE, $urandom_range(3));
        write_reg(REG_RESET_AFTER, $urandom_range(1));
      end
      if ($urandom_range(5) == 0) drain_results();
      loads = $urandom_range(10);
      repeat (loads) begin
        if ($urandom_range(9) == 0)
          send_req($urandom_range(1) ? F_UNUSED : F_LD_WIH, 6'($urandom),
                   8'($urandom_range(255, 192)), 16'($urandom));
        else random_load();
      end
      fill_missing();
      send_req(F_COMPUTE, 6'($urandom), 8'($urandom), 16'($urandom));
      if (n_reqs > 270 - 60) quiet = 1;
    end
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (quiet) out_ready <= 1'b1;
      else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if ($urandom_range(9) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(12, 1) - 1;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hidden_res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (hidden_q.size() == 0) begin
        $display("%0t: unexpected result index %0d value %0d", $time, out_index,
                 out_hidden_value);
        errors++;
      end else begin
        e = hidden_q.pop_front();
        if (out_index !== e.index) begin
          $display("%0t: index expected %0d actual %0d", $time, e.index, out_index);
          errors++;
        end
        if (out_hidden_value !== e.hval) begin
          $display("%0t: hidden value (unit %0d) expected %0d actual %0d", $time,
                   e.index, $signed(e.hval), out_hidden_value);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last (unit %0d) expected %0d actual %0d", $time, e.index,
                   e.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    errors = 0;
    n_reqs = 0;
    n_computes = 0;
    n_results = 0;
    quiet = 0;
    units_q = 64;
    feats_q = 64;
    bias_q = 0;
    after_q = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_row = '0;
    in_column = '0;
    in_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_wide_config();
    test_random();
    in_valid <= 1'b0;
    guard = 0;
    while (hidden_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (hidden_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, hidden_q.size());
      errors++;
    end
    $display("Sent %0d requests, %0d compute steps; %0d hidden values checked.",
             n_reqs, n_computes, n_results);
    $display("Covered all bias modes, both reset-gate orders, clamped and masked sizes, "
             , "cells of 1 to 4 units and features.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
